// File: design/lcu_pkg.sv
package lcu_pkg;

    localparam int CNT_W   = 16;
    localparam int SCALE_W = 19;
    localparam int PROD_W  = CNT_W + SCALE_W;
    localparam int CHAN_FRAC_BITS = 10;
    localparam int SC_W    = PROD_W - CHAN_FRAC_BITS;
    localparam int NUM_W   = SC_W + CHAN_FRAC_BITS;
    localparam int QUO_W   = 12;
    localparam int QIDX_W  = 4;
    localparam int CMP_W   = SC_W + QUO_W;
    localparam int RATIO_W = QUO_W;
    localparam int COEF_W  = 10;
    localparam int SEG_W   = 3;
    localparam int NSEG    = 8;
    localparam int LUX_PROD_W = SC_W + COEF_W;
    localparam int LUX_FRAC_BITS = 14;
    localparam int LUX_FULL_W = LUX_PROD_W + 1 - LUX_FRAC_BITS;
    localparam int LUX_W   = 16;

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS_PER_STAGE;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_IS_LOW      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRATION_MODE = 2'd1;

    localparam logic [1:0] MODE_SHORT  = 2'd0;
    localparam logic [1:0] MODE_MEDIUM = 2'd1;
    localparam logic [1:0] MODE_LONG   = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_SHORT  = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_MEDIUM = 19'h00fe7;
    localparam logic [SCALE_W-1:0] SCALE_UNIT   = 19'h00400;

    localparam logic [RATIO_W-1:0] BRK_K [0:NSEG-2] = '{
        12'h040, 12'h080, 12'h0c0, 12'h100, 12'h138, 12'h19a, 12'h29a
    };
    localparam logic [COEF_W-1:0] BRK_B [0:NSEG-1] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [COEF_W-1:0] BRK_M [0:NSEG-1] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    typedef struct packed {
        logic [SC_W-1:0]  s0;
        logic [SC_W-1:0]  s1;
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             zero;
        logic             big;
    } div_t;

    // one restoring step for quotient bit pos
    function automatic div_t div_step(div_t d, logic [QIDX_W-1:0] pos);
        logic [CMP_W-1:0] sub;
        logic [CMP_W-1:0] r;
        div_t o;
        o   = d;
        sub = CMP_W'(d.s0) << pos;
        r   = CMP_W'(d.rem);
        if (r >= sub)
        begin
            o.rem      = NUM_W'(r - sub);
            o.quo[pos] = 1'b1;
        end
        return o;
    endfunction

endpackage

// File: design/lcu_sample_if.sv
interface lcu_sample_if;
    logic                      valid;
    logic                      ready;
    logic [lcu_pkg::CNT_W-1:0] broadband_count;
    logic [lcu_pkg::CNT_W-1:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count, input ready);
    modport sink (input valid, input broadband_count, input infrared_count, output ready);
endinterface

// File: design/lcu_result_if.sv
interface lcu_result_if;
    logic                      valid;
    logic                      ready;
    logic [lcu_pkg::LUX_W-1:0] lux_level;
    logic                      lux_saturated;

    modport source (output valid, output lux_level, output lux_saturated, input ready);
    modport sink (input valid, input lux_level, input lux_saturated, output ready);
endinterface

// File: design/lcu_cfg_if.sv
interface lcu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcu_pkg::CFG_INDEX_W-1:0] index;
    logic [lcu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/lcu_scale.sv
module lcu_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      gain_is_low,
    input  logic [1:0]                integration_mode,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [lcu_pkg::CNT_W-1:0] broadband_count,
    input  logic [lcu_pkg::CNT_W-1:0] infrared_count,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lcu_pkg::div_t             out_data
);

    logic [lcu_pkg::SCALE_W-1:0] base;
    logic [lcu_pkg::SCALE_W-1:0] scale;
    logic [lcu_pkg::PROD_W-1:0]  p0_next, p1_next;
    logic [lcu_pkg::PROD_W-1:0]  p0_reg, p1_reg;
    logic                        va_reg, vb_reg;
    logic                        rdy_a, rdy_b;
    logic [lcu_pkg::SC_W-1:0]    s0, s1;
    lcu_pkg::div_t               d_next, d_reg;

    always_comb
    begin
        case (integration_mode)
            lcu_pkg::MODE_SHORT:  base = lcu_pkg::SCALE_SHORT;
            lcu_pkg::MODE_MEDIUM: base = lcu_pkg::SCALE_MEDIUM;
            default:              base = lcu_pkg::SCALE_UNIT;
        endcase
        scale = gain_is_low ? (base << 4) : base;
    end

    assign p0_next = lcu_pkg::PROD_W'(broadband_count) * lcu_pkg::PROD_W'(scale);
    assign p1_next = lcu_pkg::PROD_W'(infrared_count) * lcu_pkg::PROD_W'(scale);

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // quotient overflows 12 bits exactly when s1 >= 4*s0
    always_comb
    begin
        s0          = p0_reg[lcu_pkg::PROD_W-1:lcu_pkg::CHAN_FRAC_BITS];
        s1          = p1_reg[lcu_pkg::PROD_W-1:lcu_pkg::CHAN_FRAC_BITS];
        d_next.s0   = s0;
        d_next.s1   = s1;
        d_next.rem  = {s1, {lcu_pkg::CHAN_FRAC_BITS{1'b0}}};
        d_next.quo  = '0;
        d_next.zero = (s0 == '0);
        d_next.big  = ({2'b00, s1} >= {s0, 2'b00});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (rdy_b && va_reg)
            d_reg <= d_next;
    end

    assign out_valid = vb_reg;
    assign out_data  = d_reg;

endmodule

// File: design/lcu_div.sv
module lcu_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lcu_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lcu_pkg::div_t out_data
);

    localparam int NST = lcu_pkg::DIV_STAGES;
    localparam int NSP = lcu_pkg::DIV_STEPS_PER_STAGE;

    lcu_pkg::div_t st_reg  [NST];
    lcu_pkg::div_t st_next [NST];
    logic          v_reg   [NST];
    logic          rdy     [NST+1];
    logic          v_in    [NST];
    lcu_pkg::div_t d_in    [NST];

    assign rdy[NST] = out_ready;

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            assign v_in[j] = in_valid;
            assign d_in[j] = in_data;
        end
        else
        begin : g_rest
            assign v_in[j] = v_reg[j-1];
            assign d_in[j] = st_reg[j-1];
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        // quotient bits handled high to low, NSP per stage
        always_comb
        begin
            st_next[j] = d_in[j];
            for (int k = 0; k < NSP; k++)
                st_next[j] = lcu_pkg::div_step(st_next[j],
                    lcu_pkg::QIDX_W'(lcu_pkg::QUO_W - 1 - j * NSP - k));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (rdy[j])
                v_reg[j] <= v_in[j];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j] && v_in[j])
                st_reg[j] <= st_next[j];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

// File: design/lcu_lux.sv
module lcu_lux (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lcu_pkg::div_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [lcu_pkg::LUX_W-1:0] lux_level,
    output logic                      lux_saturated
);

    logic [lcu_pkg::RATIO_W:0]       ratio_sum;
    logic [lcu_pkg::RATIO_W-1:0]     ratio;
    logic [lcu_pkg::SEG_W-1:0]       seg;
    logic                            vr_reg, vm_reg, vf_reg;
    logic                            rdy_r, rdy_m, rdy_f;
    logic [lcu_pkg::SC_W-1:0]        s0_reg, s1_reg;
    logic [lcu_pkg::COEF_W-1:0]      b_reg, m_reg;
    logic [lcu_pkg::LUX_PROD_W-1:0]  pos_next, neg_next, pos_reg, neg_reg;
    logic [lcu_pkg::LUX_PROD_W-1:0]  diff;
    logic [lcu_pkg::LUX_PROD_W:0]    rounded;
    logic [lcu_pkg::LUX_FULL_W-1:0]  lux_full;
    logic [lcu_pkg::LUX_W-1:0]       lux_next, lux_reg;
    logic                            sat_next, sat_reg;

    // rounded ratio and segment search
    always_comb
    begin
        ratio_sum = {1'b0, in_data.quo} + 1'b1;
        ratio     = ratio_sum[lcu_pkg::RATIO_W:1];
        seg       = lcu_pkg::SEG_W'(lcu_pkg::NSEG - 1);
        for (int i = lcu_pkg::NSEG - 2; i >= 0; i--)
        begin
            if (ratio <= lcu_pkg::BRK_K[i])
                seg = lcu_pkg::SEG_W'(i);
        end
        if (in_data.zero)
            seg = '0;
        else if (in_data.big)
            seg = lcu_pkg::SEG_W'(lcu_pkg::NSEG - 1);
    end

    assign pos_next = lcu_pkg::LUX_PROD_W'(s0_reg) * lcu_pkg::LUX_PROD_W'(b_reg);
    assign neg_next = lcu_pkg::LUX_PROD_W'(s1_reg) * lcu_pkg::LUX_PROD_W'(m_reg);

    always_comb
    begin
        diff     = (pos_reg > neg_reg) ? (pos_reg - neg_reg) : '0;
        rounded  = {1'b0, diff} + (lcu_pkg::LUX_PROD_W + 1)'(1 << (lcu_pkg::LUX_FRAC_BITS - 1));
        lux_full = rounded[lcu_pkg::LUX_PROD_W:lcu_pkg::LUX_FRAC_BITS];
        sat_next = (lux_full[lcu_pkg::LUX_FULL_W-1:lcu_pkg::LUX_W] != '0);
        lux_next = sat_next ? '1 : lux_full[lcu_pkg::LUX_W-1:0];
    end

    assign rdy_f    = !vf_reg || out_ready;
    assign rdy_m    = !vm_reg || rdy_f;
    assign rdy_r    = !vr_reg || rdy_m;
    assign in_ready = rdy_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            vm_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (rdy_r)
                vr_reg <= in_valid;
            if (rdy_m)
                vm_reg <= vr_reg;
            if (rdy_f)
                vf_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_r && in_valid)
        begin
            s0_reg <= in_data.s0;
            s1_reg <= in_data.s1;
            b_reg  <= lcu_pkg::BRK_B[seg];
            m_reg  <= lcu_pkg::BRK_M[seg];
        end
        if (rdy_m && vr_reg)
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
        if (rdy_f && vm_reg)
        begin
            lux_reg <= lux_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid     = vf_reg;
    assign lux_level     = lux_reg;
    assign lux_saturated = sat_reg;

endmodule

// File: design/light_sensor_lux_calc_unit.sv
// Two-channel lux calculation: each accepted pair of raw counts on sample gives exactly one
// lux transaction on result, in order. A new pair can be taken every cycle when result is
// not stalled. The pipeline is built from the 12-bit restoring ratio divider, split two
// quotient bits per stage over six stages, plus two stages for count scaling and three for
// segment lookup, multiply and rounding. Each stage holds its item under backpressure, so
// stalls lose nothing. Gain and integration mode are written on cfg (index 0 and 1, other
// indexes ignored) and must only change while no transaction is in flight.
module light_sensor_lux_calc_unit (
    input  logic          clk,
    input  logic          rst_n,
    lcu_cfg_if.sink       cfg,
    lcu_sample_if.sink    sample,
    lcu_result_if.source  result
);

    logic          gain_reg;
    logic [1:0]    mode_reg;
    logic          sc_valid, sc_ready;
    lcu_pkg::div_t sc_data;
    logic          dv_valid, dv_ready;
    lcu_pkg::div_t dv_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 1'b0;
            mode_reg <= lcu_pkg::MODE_LONG;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lcu_pkg::REG_GAIN_IS_LOW:      gain_reg <= cfg.data[0];
                lcu_pkg::REG_INTEGRATION_MODE: mode_reg <= cfg.data[1:0];
                default:                       ;
            endcase
        end
    end

    lcu_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .gain_is_low      (gain_reg),
        .integration_mode (mode_reg),
        .in_valid         (sample.valid),
        .in_ready         (sample.ready),
        .broadband_count  (sample.broadband_count),
        .infrared_count   (sample.infrared_count),
        .out_valid        (sc_valid),
        .out_ready        (sc_ready),
        .out_data         (sc_data)
    );

    lcu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_data   (sc_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    lcu_lux u_lux (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (dv_valid),
        .in_ready      (dv_ready),
        .in_data       (dv_data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .lux_level     (result.lux_level),
        .lux_saturated (result.lux_saturated)
    );

endmodule

// File: bench/tb_top.sv
module tb_top;

    // integration-time factors in 2^-10 units
    localparam logic [63:0] FACTOR_13MS  = 64'h7517;
    localparam logic [63:0] FACTOR_101MS = 64'h0fe7;
    localparam logic [63:0] FACTOR_UNIT  = 64'd1024;
    localparam int SCALED_SHIFT = 10;
    localparam int RATIO_FRAC   = 9;
    localparam int LUX_SHIFT    = 14;
    localparam logic [63:0] LUX_MAX = 64'hffff;

    localparam logic [lcu_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [lcu_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [lcu_pkg::CFG_DATA_W-1:0]  MODE_LONG_ALT = 2'd3;
    localparam logic [lcu_pkg::CFG_DATA_W-1:0]  GAIN_16X      = 2'b00;
    localparam logic [lcu_pkg::CFG_DATA_W-1:0]  GAIN_1X       = 2'b01;
    localparam logic [lcu_pkg::CFG_DATA_W-1:0]  GAIN_16X_JUNK = 2'b10;
    localparam logic [lcu_pkg::CFG_DATA_W-1:0]  GAIN_1X_JUNK  = 2'b11;

    localparam int CYCLE_LIMIT = 200000;
    localparam int END_SLACK   = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [lcu_pkg::CNT_W-1:0] broadband;
        logic [lcu_pkg::CNT_W-1:0] infrared;
    } sample_t;

    typedef struct packed {
        logic [lcu_pkg::LUX_W-1:0] lux;
        logic                      sat;
    } lux_result_t;

    typedef struct packed {
        logic [lcu_pkg::CFG_INDEX_W-1:0] index;
        logic [lcu_pkg::CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    lcu_cfg_if    cfg_ch ();
    lcu_sample_if sample_ch ();
    lcu_result_if result_ch ();

    light_sensor_lux_calc_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    sample_t     sample_pending [$];
    lux_result_t lux_expected [$];
    reg_write_t  reg_pending [$];

    // shadow of the block's settings, as seen by the predictor
    logic       gain_low_shadow = 1'b0;
    logic [1:0] mode_shadow     = lcu_pkg::MODE_LONG;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;
    event hold_go;

    int errors          = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int saturated_seen  = 0;
    int zero_lux_seen   = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [11:0] seg_limit(input int i);
        case (i)
            0: return 12'h040;
            1: return 12'h080;
            2: return 12'h0c0;
            3: return 12'h100;
            4: return 12'h138;
            5: return 12'h19a;
            default: return 12'h29a;
        endcase
    endfunction

    function automatic lux_result_t predict_lux(input logic [lcu_pkg::CNT_W-1:0] c0,
                                                input logic [lcu_pkg::CNT_W-1:0] c1,
                                                input logic gain_low,
                                                input logic [1:0] mode);
        logic [63:0] factor, s0, s1, quot, ratio, b, m, pos, neg, lux;
        int seg;
        int i;
        lux_result_t r;
        case (mode)
            lcu_pkg::MODE_SHORT:  factor = FACTOR_13MS;
            lcu_pkg::MODE_MEDIUM: factor = FACTOR_101MS;
            default:              factor = FACTOR_UNIT;
        endcase
        if (gain_low)
            factor = factor << 4;
        s0 = (64'(c0) * factor) >> SCALED_SHIFT;
        s1 = (64'(c1) * factor) >> SCALED_SHIFT;
        // ratio counts as zero when there is no broadband light
        quot = 64'd0;
        if (s0 != 64'd0)
            quot = (s1 << (RATIO_FRAC + 1)) / s0;
        ratio = (quot + 64'd1) >> 1;
        seg = 7;
        for (i = 6; i >= 0; i--)
            if (ratio <= 64'(seg_limit(i)))
                seg = i;
        case (seg)
            0: begin b = 64'h1f2; m = 64'h1be; end
            1: begin b = 64'h214; m = 64'h2d1; end
            2: begin b = 64'h23f; m = 64'h37b; end
            3: begin b = 64'h270; m = 64'h3fe; end
            4: begin b = 64'h16f; m = 64'h1fc; end
            5: begin b = 64'h0d2; m = 64'h0fb; end
            6: begin b = 64'h018; m = 64'h012; end
            default: begin b = 64'h000; m = 64'h000; end
        endcase
        pos = s0 * b;
        neg = s1 * m;
        lux = (pos > neg) ? (pos - neg) : 64'd0;
        lux = (lux + (64'd1 << (LUX_SHIFT - 1))) >> LUX_SHIFT;
        if (lux > LUX_MAX)
        begin
            r.lux = '1;
            r.sat = 1'b1;
        end
        else
        begin
            r.lux = lux[lcu_pkg::LUX_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int pick;
        logic [31:0] c0, c1;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            c0 = $urandom & 32'hffff;
            c1 = $urandom & 32'hffff;
        end
        else if (pick < 50)
        begin
            // spread the infrared/broadband ratio over every segment
            c0 = $urandom_range(1, 65535);
            c1 = (c0 * $urandom_range(0, 800)) >> RATIO_FRAC;
        end
        else if (pick < 75)
        begin
            // ratio just either side of a breakpoint
            c0 = $urandom_range(64, 65535);
            c1 = ((c0 * 32'(seg_limit($urandom_range(0, 6)))) >> RATIO_FRAC)
                 + $urandom_range(0, 2);
            if (c1 != 0)
                c1 = c1 - 1;
        end
        else if (pick < 88)
        begin
            c0 = $urandom_range(0, 15);
            c1 = $urandom_range(0, 15);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: c0 = 0;
                1: c0 = 1;
                2: c0 = 65534;
                default: c0 = 65535;
            endcase
            case ($urandom_range(0, 3))
                0: c1 = 0;
                1: c1 = 1;
                2: c1 = 65534;
                default: c1 = 65535;
            endcase
        end
        if (c1 > 65535)
            c1 = 65535;
        s.broadband = c0[lcu_pkg::CNT_W-1:0];
        s.infrared  = c1[lcu_pkg::CNT_W-1:0];
        return s;
    endfunction

    task automatic push_sample(input logic [lcu_pkg::CNT_W-1:0] c0,
                               input logic [lcu_pkg::CNT_W-1:0] c1);
        sample_pending.push_back('{broadband: c0, infrared: c1});
    endtask

    task automatic queue_reg(input logic [lcu_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lcu_pkg::CFG_DATA_W-1:0] data);
        reg_pending.push_back('{index: idx, data: data});
    endtask

    task automatic wait_drained();
        while (sample_pending.size() != 0 || lux_expected.size() != 0 ||
               reg_pending.size() != 0)
            @(negedge clk);
    endtask

    // settings only change once every earlier transaction has left the block
    task automatic set_gain_mode(input logic [lcu_pkg::CFG_DATA_W-1:0] gain,
                                 input logic [lcu_pkg::CFG_DATA_W-1:0] mode);
        wait_drained();
        queue_reg(lcu_pkg::REG_GAIN_IS_LOW, gain);
        queue_reg(lcu_pkg::REG_INTEGRATION_MODE, mode);
    endtask

    task automatic run_random(input int send_pct, input int recv_pct, input int n);
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n)
            sample_pending.push_back(random_sample());
    endtask

    // register write transactions; the shadow follows each accepted one
    always @(posedge clk)
    begin : drive_regs
        if (!rst_n)
            cfg_ch.valid <= 1'b0;
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    lcu_pkg::REG_GAIN_IS_LOW:      gain_low_shadow = cfg_ch.data[0];
                    lcu_pkg::REG_INTEGRATION_MODE: mode_shadow = cfg_ch.data;
                    default: ;
                endcase
                void'(reg_pending.pop_front());
                reg_writes++;
            end
            if (cfg_ch.valid && !cfg_ch.ready)
                ;
            else if (reg_pending.size() != 0)
            begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= reg_pending[0].index;
                cfg_ch.data  <= reg_pending[0].data;
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : drive_samples
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                lux_expected.push_back(predict_lux(sample_ch.broadband_count,
                                                   sample_ch.infrared_count,
                                                   gain_low_shadow, mode_shadow));
                void'(sample_pending.pop_front());
                samples_sent++;
            end
            if (sample_ch.valid && !sample_ch.ready)
                ;
            else if (sample_pending.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample_ch.valid           <= 1'b1;
                sample_ch.broadband_count <= sample_pending[0].broadband;
                sample_ch.infrared_count  <= sample_pending[0].infrared;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        lux_result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (lux_expected.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result transaction lux=%0d sat=%0b",
                                 $time, result_ch.lux_level, result_ch.lux_saturated);
                    errors++;
                end
                else
                begin
                    want = lux_expected.pop_front();
                    if (want.lux !== result_ch.lux_level)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: lux_level expected %0d actual %0d",
                                     $time, want.lux, result_ch.lux_level);
                        errors++;
                    end
                    if (want.sat !== result_ch.lux_saturated)
                    begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: lux_saturated expected %0b actual %0b",
                                     $time, want.sat, result_ch.lux_saturated);
                        errors++;
                    end
                    results_checked++;
                    if (want.sat)
                        saturated_seen++;
                    if (want.lux == '0)
                        zero_lux_seen++;
                end
            end
            if (recv_hold)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the pipeline fills and pushes back on sample
    initial
    begin : hold_off
        forever
        begin
            @(hold_go);
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            recv_hold = 1'b0;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, lux_expected.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.broadband_count = '0;
        sample_ch.infrared_count  = '0;
        result_ch.ready           = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: unit scaling so breakpoints land exactly
        push_sample(16'd0, 16'd0);
        push_sample(16'd0, 16'hffff);
        push_sample(16'hffff, 16'd0);
        push_sample(16'hffff, 16'hffff);
        push_sample(16'd1, 16'd0);
        push_sample(16'd0, 16'd1);
        push_sample(16'd1, 16'd1);
        push_sample(16'hffff, 16'd1);
        push_sample(16'd1, 16'hffff);
        for (i = 0; i < 7; i++)
        begin
            push_sample(16'd4096, 16'(seg_limit(i)) << 3);
            push_sample(16'd4096, (16'(seg_limit(i)) << 3) + 16'd1);
        end
        wait_drained();

        set_gain_mode(GAIN_16X, lcu_pkg::MODE_SHORT);
        run_random(0, 0, 200);

        set_gain_mode(GAIN_1X, lcu_pkg::MODE_SHORT);
        run_random(54, 0, 200);

        set_gain_mode(GAIN_1X, lcu_pkg::MODE_MEDIUM);
        run_random(0, 54, 200);

        set_gain_mode(GAIN_16X, lcu_pkg::MODE_MEDIUM);
        run_random(35, 35, 200);

        // upper data bits ignored for gain, mode 3 behaves as the long setting
        set_gain_mode(GAIN_1X_JUNK, MODE_LONG_ALT);
        run_random(0, 0, 150);
        -> hold_go;

        // writes to unused indexes must leave the settings alone
        set_gain_mode(GAIN_16X_JUNK, lcu_pkg::MODE_LONG);
        queue_reg(REG_SPARE_LO, 2'b11);
        queue_reg(REG_SPARE_HI, 2'b01);
        run_random(35, 35, 200);

        set_gain_mode(GAIN_1X, lcu_pkg::MODE_LONG);
        run_random(54, 0, 200);

        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (lux_expected.size() != 0)
            errors++;

        $display("covered %0d sample pairs over %0d register writes: both gains, all modes",
                 samples_sent, reg_writes);
        $display("checked %0d results (%0d saturated, %0d at zero lux), %0d mismatches",
                 results_checked, saturated_seen, zero_lux_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
design/lcu_pkg.sv
design/lcu_sample_if.sv
design/lcu_result_if.sv
design/lcu_cfg_if.sv
design/lcu_scale.sv
design/lcu_div.sv
design/lcu_lux.sv
design/light_sensor_lux_calc_unit.sv
bench/tb_top.sv
